@@ rtl/core/dsts_pkg.sv @@
// ----------------------------------------------------------------------------
// dsts_pkg
// Shared types, register codes and the raised cosine wave table for the
// dual channel sine table synthesizer.
// ----------------------------------------------------------------------------
package dsts_pkg;

	// Table geometry and duty range
	localparam int TABLE_DEPTH = 1024;
	localparam int DUTY_RANGE  = 1024;
	localparam int HALF_RANGE  = DUTY_RANGE / 2;
	localparam int POS_W       = $clog2(TABLE_DEPTH);
	localparam int STEP_W      = 10;
	localparam int SUM_W       = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
	localparam int DUTY_W      = 11;
	localparam int MODE_W      = 2;

	// Stream and config port widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = ((DUTY_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = STEP_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_ONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_TWO = 2'd2;

	// Channel mode codes (zero acts as channel one only)
	localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BOTH = 2'd3;

	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef duty_t wave_table_t [TABLE_DEPTH];

	// pi in Q60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// floor(a*b / 2^60), operands below 2^62
	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Shift-subtract quotient, used only while the table is built
	function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] dvs);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, dvs}) begin
				rem  = rem - {1'b0, dvs};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series sine in Q60 for 0 <= x <= pi/2
	function automatic logic [63:0] sin_q60(logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] den;
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		for (int n = 1; n < 40; n++) begin
			if (term != 64'd0) begin
				den  = 64'((2 * n) * (2 * n + 1));
				term = div_u64(mul_q60(term, x2), den);
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

	// One table entry: 2H * sin^2(pi*i/N), exact at rational cosine points
	function automatic logic [31:0] table_entry(int i);
		logic [31:0] h;
		logic [31:0] k;
		logic [63:0] j;
		logic [63:0] phi;
		logic [63:0] s;
		logic [63:0] s2;
		logic [63:0] twoh;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		h = 32'(HALF_RANGE);
		if ((12 * i) % TABLE_DEPTH == 0) begin
			k = 32'((12 * i) / TABLE_DEPTH);
			case (k) inside
				0:     return 32'd0;
				2, 10: return h >> 1;
				3, 9:  return h;
				4, 8:  return h + (h >> 1);
				6:     return 2 * h;
				default: ;
			endcase
		end
		j    = (2 * i > TABLE_DEPTH) ? 64'(TABLE_DEPTH - i) : 64'(i);
		phi  = (PI_Q60 / TABLE_DEPTH) * j + ((PI_Q60 % TABLE_DEPTH) * j) / TABLE_DEPTH;
		s    = sin_q60(phi);
		s2   = mul_q60(s, s);
		twoh = 64'(2 * HALF_RANGE);
		a    = twoh * (s2 >> 30);
		b    = twoh * (s2 & 64'h3FFF_FFFF);
		r    = (a + (b >> 30)) >> 30;
		return r[31:0];
	endfunction

	// Whole table, built at elaboration
	function automatic wave_table_t build_table();
		wave_table_t t;
		logic [31:0] v;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			v    = table_entry(i);
			t[i] = v[DUTY_W-1:0];
		end
		return t;
	endfunction

	localparam wave_table_t WAVE_TABLE = build_table();

endpackage

@@ rtl/core/dual_channel_sine_table_synth.sv @@
// ----------------------------------------------------------------------------
// dual_channel_sine_table_synth
// Two channel raised cosine synthesizer that fills PWM FIFO slots.
// ----------------------------------------------------------------------------
// Every input word with slot_free set returns one duty word, in the cycle after
// it is taken, read from a 1024 entry raised cosine ROM at the serving
// channel's position; the position then steps by step_one or step_two and
// wraps at the table length. A word with slot_free clear is consumed with no
// result. The block takes one word per clock: the position update is one add
// and one conditional subtract, and the single registered ROM read port
// feeds the output register directly. The output register holds a result
// while m_tready is low and the input stalls only in that case. channel_mode
// picks channel one, channel two, or both alternating from channel one.
// Write the config registers only while no words are in flight.
module dual_channel_sine_table_synth (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [dsts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsts_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dsts_pkg::IN_TDATA_W-1:0]    s_tdata,  // [0] slot_free
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dsts_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [10:0] duty_value
	output logic                               m_tuser   // [0] channel_index
);
	import dsts_pkg::*;

	logic [MODE_W-1:0] mode_q;
	step_t             step_one_q;
	step_t             step_two_q;
	pos_t              pos_one_q;
	pos_t              pos_two_q;
	logic              next_two_q;

	logic              out_valid_s1;
	duty_t             duty_s1;
	logic              chan_s1;

	logic              accept;
	logic              fire;
	logic              use_two;
	pos_t              rd_addr;
	step_t             step_sel;
	logic [SUM_W-1:0]  pos_sum;
	pos_t              pos_next;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_ONE;
			step_one_q <= step_t'(1);
			step_two_q <= step_t'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				REG_STEP_ONE: step_one_q <= cfg_data[STEP_W-1:0];
				REG_STEP_TWO: step_two_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign s_tready = !out_valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign fire     = accept && s_tdata[0];

	// Channel select
	always_comb begin
		case (mode_q)
			MODE_TWO:  use_two = 1'b1;
			MODE_BOTH: use_two = next_two_q;
			default:   use_two = 1'b0;
		endcase
	end

	// Phase step with single wrap
	assign rd_addr  = use_two ? pos_two_q : pos_one_q;
	assign step_sel = use_two ? step_two_q : step_one_q;
	assign pos_sum  = SUM_W'(rd_addr) + SUM_W'(step_sel);
	assign pos_next = (pos_sum >= SUM_W'(TABLE_DEPTH))
		? POS_W'(pos_sum - SUM_W'(TABLE_DEPTH)) : POS_W'(pos_sum);

	// Channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_one_q  <= '0;
			pos_two_q  <= '0;
			next_two_q <= 1'b0;
		end else if (fire) begin
			if (use_two) begin
				pos_two_q <= pos_next;
			end else begin
				pos_one_q <= pos_next;
			end
			if (mode_q == MODE_BOTH) begin
				next_two_q <= !next_two_q;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			out_valid_s1 <= fire;
		end
	end

	// ROM read into the output register
	always_ff @(posedge clk) begin
		if (fire) begin
			duty_s1 <= WAVE_TABLE[rd_addr];
			chan_s1 <= use_two;
		end
	end

	assign m_tvalid = out_valid_s1;
	assign m_tdata  = OUT_TDATA_W'(duty_s1);
	assign m_tuser  = chan_s1;

	// Checks
	a_result_per_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tvalid == $past(s_tdata[0])))
		else $error("result count does not match free slots");

	a_mode_two_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_q == MODE_TWO) |=> (m_tvalid && m_tuser))
		else $error("channel two only mode served channel one");

	a_alternate: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_q == MODE_BOTH) |=> (next_two_q != $past(next_two_q)))
		else $error("alternating mode did not toggle channel");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pos_one_q) < TABLE_DEPTH) && (32'(pos_two_q) < TABLE_DEPTH))
		else $error("position outside table");

endmodule
